>>> hw/rtl/brl_pkg.sv
`default_nettype none

package brl_pkg;

    // Coordinate width, fixed by the pixel fields.
    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 1;
    localparam int COLOR_BITS = 32;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    // Input beat.
    typedef struct packed {
        t_op                            op;
        logic signed [COORD_BITS-1:0]   x_start;
        logic signed [COORD_BITS-1:0]   y_start;
        logic signed [COORD_BITS-1:0]   x_end;
        logic signed [COORD_BITS-1:0]   y_end;
        logic [COLOR_BITS-1:0]          color;
    } t_in_beat;

    // Output beat.
    typedef struct packed {
        logic signed [COORD_BITS-1:0]   pixel_x;
        logic signed [COORD_BITS-1:0]   pixel_y;
        logic [COLOR_BITS-1:0]          pixel_color;
        logic                           last;
    } t_pix_beat;

    // Classified command handed from front to back through the queue.
    typedef struct packed {
        t_op                            op;
        logic signed [COORD_BITS-1:0]   x0;
        logic signed [COORD_BITS-1:0]   y0;
        logic [COORD_BITS-1:0]          adx;
        logic [COORD_BITS-1:0]          ady;
        logic                           x_neg;
        logic                           y_neg;
        logic                           x_major;
        logic [COLOR_BITS-1:0]          color;
    } t_cmd;

    // Queue status toward the front and back ends.
    typedef struct packed {
        logic   not_empty;
        logic   full;
    } t_q_status;

endpackage

`default_nettype wire

>>> hw/rtl/brl_front.sv
`default_nettype none

// Front end: takes input beats, works out line setup for starts.
module brl_front (
    input  wire                  i_in_valid,
    input  brl_pkg::t_in_beat    i_in_data,
    input  brl_pkg::t_q_status   i_q_status,
    output logic                 o_in_stall,
    output logic                 o_push,
    output brl_pkg::t_cmd        o_cmd
);

    localparam int CW = brl_pkg::COORD_BITS;

    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [CW:0]        adx_w;
    logic [CW:0]        ady_w;
    logic [CW-1:0]      adx;
    logic [CW-1:0]      ady;

    always_comb begin
        dx    = $signed({i_in_data.x_end[CW-1], i_in_data.x_end})
              - $signed({i_in_data.x_start[CW-1], i_in_data.x_start});
        dy    = $signed({i_in_data.y_end[CW-1], i_in_data.y_end})
              - $signed({i_in_data.y_start[CW-1], i_in_data.y_start});
        adx_w = dx[CW] ? (~dx + 1'b1) : dx;
        ady_w = dy[CW] ? (~dy + 1'b1) : dy;
        adx   = adx_w[CW-1:0];
        ady   = ady_w[CW-1:0];
    end

    always_comb begin
        o_cmd.op      = i_in_data.op;
        o_cmd.x0      = i_in_data.x_start;
        o_cmd.y0      = i_in_data.y_start;
        o_cmd.adx     = adx;
        o_cmd.ady     = ady;
        // zero delta counts as negative direction
        o_cmd.x_neg   = dx[CW] || (dx == '0);
        o_cmd.y_neg   = dy[CW] || (dy == '0);
        // tie goes to y
        o_cmd.x_major = adx > ady;
        o_cmd.color   = i_in_data.color;
    end

    assign o_in_stall = i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

endmodule

`default_nettype wire

>>> hw/rtl/brl_queue.sv
`default_nettype none

// Short command queue between front and back.
module brl_queue #(
    parameter int DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  brl_pkg::t_cmd        i_push_cmd,
    input  wire                  i_pop,
    output brl_pkg::t_cmd        o_head_cmd,
    output brl_pkg::t_q_status   o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(DEPTH);

    brl_pkg::t_cmd   r_store [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;
    logic [PW-1:0]   n_wr_ptr;
    logic [PW-1:0]   n_rd_ptr;
    logic [NW-1:0]   n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_head_cmd          = r_store[r_rd_ptr];
    assign o_status.not_empty  = (r_count != '0);
    assign o_status.full       = (r_count == FULL_CNT);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_status.not_empty |-> !i_pop)
        else $error("queue pop while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> hw/rtl/brl_back.sv
`default_nettype none

// Back end: holds line state, steps it and registers the pixel beat.
module brl_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  brl_pkg::t_cmd        i_head_cmd,
    input  brl_pkg::t_q_status   i_q_status,
    output logic                 o_pop,
    input  wire                  i_out_stall,
    output logic                 o_out_valid,
    output brl_pkg::t_pix_beat   o_out_data
);

    localparam int CW = brl_pkg::COORD_BITS;
    localparam int EW = brl_pkg::ERR_BITS;

    logic signed [CW-1:0]           r_cur_x;
    logic signed [CW-1:0]           r_cur_y;
    logic [CW-1:0]                  r_major;
    logic [CW-1:0]                  r_minor;
    logic                           r_x_neg;
    logic                           r_y_neg;
    logic                           r_x_major;
    logic [EW-1:0]                  r_err;
    logic [CW-1:0]                  r_steps;
    logic [brl_pkg::COLOR_BITS-1:0] r_color;
    logic                           r_busy;
    logic                           r_out_valid;
    brl_pkg::t_pix_beat             r_out;

    logic signed [CW-1:0]           n_cur_x;
    logic signed [CW-1:0]           n_cur_y;
    logic [CW-1:0]                  n_major;
    logic [CW-1:0]                  n_minor;
    logic                           n_x_neg;
    logic                           n_y_neg;
    logic                           n_x_major;
    logic [EW-1:0]                  n_err;
    logic [CW-1:0]                  n_steps;
    logic [brl_pkg::COLOR_BITS-1:0] n_color;
    logic                           n_busy;
    logic                           emit;

    logic                           out_free;
    logic [EW-1:0]                  err_sum;
    logic                           minor_moves;
    logic signed [CW-1:0]           x_stepped;
    logic signed [CW-1:0]           y_stepped;
    logic [CW-1:0]                  st_major;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = i_q_status.not_empty && out_free;

    always_comb begin
        err_sum     = r_err + {1'b0, r_minor};
        minor_moves = err_sum >= {1'b0, r_major};
        x_stepped   = r_cur_x + (r_x_neg ? {CW{1'b1}} : CW'(1));
        y_stepped   = r_cur_y + (r_y_neg ? {CW{1'b1}} : CW'(1));
        st_major    = i_head_cmd.x_major ? i_head_cmd.adx : i_head_cmd.ady;
    end

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_major   = r_major;
        n_minor   = r_minor;
        n_x_neg   = r_x_neg;
        n_y_neg   = r_y_neg;
        n_x_major = r_x_major;
        n_err     = r_err;
        n_steps   = r_steps;
        n_color   = r_color;
        n_busy    = r_busy;
        emit      = 1'b0;
        if (o_pop) begin
            case (i_head_cmd.op)
                brl_pkg::OP_START: begin
                    n_cur_x   = i_head_cmd.x0;
                    n_cur_y   = i_head_cmd.y0;
                    n_x_neg   = i_head_cmd.x_neg;
                    n_y_neg   = i_head_cmd.y_neg;
                    n_x_major = i_head_cmd.x_major;
                    n_major   = st_major;
                    n_minor   = i_head_cmd.x_major ? i_head_cmd.ady : i_head_cmd.adx;
                    n_err     = {1'b0, st_major >> 1};
                    n_steps   = '0;
                    n_color   = i_head_cmd.color;
                    n_busy    = (st_major != '0);
                    emit      = 1'b1;
                end
                brl_pkg::OP_STEP: begin
                    // a step with no line in progress is dropped
                    if (r_busy) begin
                        n_err   = minor_moves ? err_sum - {1'b0, r_major} : err_sum;
                        n_cur_x = (r_x_major || minor_moves) ? x_stepped : r_cur_x;
                        n_cur_y = (!r_x_major || minor_moves) ? y_stepped : r_cur_y;
                        n_steps = r_steps + 1'b1;
                        n_busy  = !(n_steps >= r_major);
                        emit    = 1'b1;
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        r_cur_x   <= n_cur_x;
        r_cur_y   <= n_cur_y;
        r_major   <= n_major;
        r_minor   <= n_minor;
        r_x_neg   <= n_x_neg;
        r_y_neg   <= n_y_neg;
        r_x_major <= n_x_major;
        r_err     <= n_err;
        r_steps   <= n_steps;
        r_color   <= n_color;
        if (emit) begin
            r_out.pixel_x     <= n_cur_x;
            r_out.pixel_y     <= n_cur_y;
            r_out.pixel_color <= n_color;
            r_out.last        <= !n_busy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_busy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_major != '0))
        else $error("busy with zero-length line");

    a_err_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_err < {1'b0, r_major}))
        else $error("error accumulator out of range");

    a_steps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_steps < r_major))
        else $error("step count past line end");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_busy == 1'b0) |=> (!r_busy && r_out.last))
        else $error("final pixel did not end the line");

endmodule

`default_nettype wire

>>> hw/rtl/bresenham_line_raster_unit.sv
`default_nettype none

// Bresenham line rasterizer. An op=START beat carries both endpoints and a
// color; it emits the first pixel and arms the line. Each op=STEP beat then
// emits the next pixel along the line, one unit on the major axis (x only
// when |dx| > |dy|, ties go to y), with the minor axis moving whenever the
// error term reaches the major delta. The line has |major delta| + 1 pixels;
// the final one carries last=1 and the unit goes idle. A STEP with no line in
// progress produces no pixel; a START during a line abandons it. A front end
// computes deltas, directions and the major axis, a command queue of
// QUEUE_DEPTH entries decouples it from the back end, and the back end holds
// line state and a registered pixel beat. Sustained rate is one input beat and
// one pixel beat per clock while the output side does not stall; the back
// end's error update is the loop that sets this. When nothing stalls, an
// accepted input beat goes into the queue, and the back end pops it and
// registers its pixel beat. The input side stalls only while the queue is
// full, which happens when the output side has been stalled.
module bresenham_line_raster_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // input channel
    input  wire                  i_in_valid,
    input  brl_pkg::t_in_beat    i_in_data,
    output logic                 o_in_stall,
    // pixel channel
    output logic                 o_out_valid,
    output brl_pkg::t_pix_beat   o_out_data,
    input  wire                  i_out_stall
);

    brl_pkg::t_q_status q_status;
    brl_pkg::t_cmd      push_cmd;
    brl_pkg::t_cmd      head_cmd;
    logic               push;
    logic               pop;

    // setup and classification of each input beat
    brl_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_status (q_status),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // command queue
    brl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .i_pop      (pop),
        .o_head_cmd (head_cmd),
        .o_status   (q_status)
    );

    // line stepping and pixel output register
    brl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_cmd  (head_cmd),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/line_raster_tb_pkg.sv
`timescale 1ns / 100ps

package line_raster_tb_pkg;

    import brl_pkg::*;

    // Tracks line state from accepted input beats and checks pixel beats in order.
    class pixel_scoreboard;
        bit signed [COORD_BITS-1:0] pos_x;
        bit signed [COORD_BITS-1:0] pos_y;
        bit [COORD_BITS-1:0]        major_len;
        bit [COORD_BITS-1:0]        minor_len;
        bit [COORD_BITS-1:0]        steps_done;
        bit [ERR_BITS-1:0]          err_acc;
        bit [COLOR_BITS-1:0]        line_color;
        bit                         x_neg;
        bit                         y_neg;
        bit                         x_major;
        bit                         busy;
        t_pix_beat                  expected_pixels[$];
        int                         errors;

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_beat(t_in_beat b);
            int        dx;
            int        dy;
            int        adx;
            int        ady;
            bit        minor_moves;
            t_pix_beat px;
            if (b.op == OP_START) begin
                dx = int'(b.x_end) - int'(b.x_start);
                dy = int'(b.y_end) - int'(b.y_start);
                adx = (dx < 0) ? -dx : dx;
                ady = (dy < 0) ? -dy : dy;
                pos_x = b.x_start;
                pos_y = b.y_start;
                // zero delta counts as negative direction
                x_neg = !(dx > 0);
                y_neg = !(dy > 0);
                x_major = adx > ady;   // tie goes to y
                major_len = COORD_BITS'(x_major ? adx : ady);
                minor_len = COORD_BITS'(x_major ? ady : adx);
                err_acc = ERR_BITS'(major_len >> 1);
                steps_done = '0;
                line_color = b.color;
                busy = major_len != 0;
            end else begin
                if (!busy)
                    return;
                err_acc = err_acc + ERR_BITS'(minor_len);
                minor_moves = err_acc >= ERR_BITS'(major_len);
                if (minor_moves)
                    err_acc = err_acc - ERR_BITS'(major_len);
                if (x_major || minor_moves)
                    pos_x = x_neg ? pos_x - 1 : pos_x + 1;
                if (!x_major || minor_moves)
                    pos_y = y_neg ? pos_y - 1 : pos_y + 1;
                steps_done = steps_done + 1;
                if (steps_done >= major_len)
                    busy = 1'b0;
            end
            px.pixel_x = pos_x;
            px.pixel_y = pos_y;
            px.pixel_color = line_color;
            px.last = !busy;
            expected_pixels.push_back(px);
        endfunction

        function void check_pixel(t_pix_beat got);
            t_pix_beat want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%0d",
                         $time, got.pixel_x, got.pixel_y, got.pixel_color, got.last);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_x !== want.pixel_x) begin
                $display("%0t: pixel_x expected %0d got %0d", $time, want.pixel_x, got.pixel_x);
                errors++;
            end
            if (got.pixel_y !== want.pixel_y) begin
                $display("%0t: pixel_y expected %0d got %0d", $time, want.pixel_y, got.pixel_y);
                errors++;
            end
            if (got.pixel_color !== want.pixel_color) begin
                $display("%0t: pixel_color expected %h got %h",
                         $time, want.pixel_color, got.pixel_color);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last expected %0d got %0d", $time, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import brl_pkg::*;
    import line_raster_tb_pkg::*;

    localparam int ITEM_TARGET = 1150;
    // Worst case is far below this: ~1.2k beats, each with an optional gap
    // plus output stalls, and lines capped in length.
    localparam int CYCLE_LIMIT = 400000;
    localparam int CMAX        = (1 << (COORD_BITS - 1)) - 1;
    localparam int CMIN        = -CMAX - 1;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_data   = '0;
    logic      in_stall;
    logic      out_valid;
    t_pix_beat out_data;
    logic      out_stall = 1'b0;

    // Both sides run without gaps while quiet is high.
    logic      quiet     = 1'b0;
    int        cycle_count = 0;
    // Beats that the block acts on: starts, and steps while a line is active.
    int        n_items   = 0;
    bit        pressure_done = 1'b0;

    pixel_scoreboard sb = new();

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bresenham_line_raster_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    // Pixel side: check accepted beats, then pick the stall for the next cycle.
    // Values read here are the pre-edge ones, i.e. what the block saw.
    always @(posedge clk) begin
        if (out_valid && !out_stall)
            sb.check_pixel(out_data);
        out_stall <= !quiet && ($urandom_range(99) < 24);
    end

    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Drive one input beat and hold it until accepted. An optional gap comes first;
    // in_valid gets only one update per time step either way.
    task automatic send_beat(t_in_beat b);
        if (!quiet && $urandom_range(99) < 16) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        if (b.op == OP_START || sb.busy)
            n_items++;
        sb.note_beat(b);
    endtask

    function automatic t_in_beat random_beat();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return r[$bits(t_in_beat)-1:0];
    endfunction

    task automatic send_start(int x0, int y0, int x1, int y1, logic [COLOR_BITS-1:0] color);
        t_in_beat b;
        b = random_beat();
        b.op = OP_START;
        b.x_start = COORD_BITS'(x0);
        b.y_start = COORD_BITS'(y0);
        b.x_end   = COORD_BITS'(x1);
        b.y_end   = COORD_BITS'(y1);
        b.color   = color;
        send_beat(b);
    endtask

    // Endpoint fields of a step carry random junk; the block must ignore them.
    task automatic send_step();
        t_in_beat b;
        b = random_beat();
        b.op = OP_STEP;
        send_beat(b);
    endtask

    // Hold the input off until every expected pixel is out.
    task automatic drain_pixels();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic int near_coord(int base, int span);
        int d;
        d = $urandom_range(span);
        if ($urandom_range(1))
            d = -d;
        if (base + d > CMAX || base + d < CMIN)
            d = -d;
        return base + d;
    endfunction

    // One random line. Mostly short, fully stepped lines; a few medium ones;
    // rare huge ones cut short. Some lines are abandoned early by the next
    // start, some get extra steps after the last pixel, and a few rounds are
    // just stray steps.
    task automatic random_line();
        int r;
        int sz;
        int m;
        int limit;
        int n;
        int x0;
        int y0;
        int x1;
        int y1;
        r = $urandom_range(99);
        if (r < 6) begin
            repeat ($urandom_range(1, 2)) send_step();
            return;
        end
        x0 = int'($urandom_range(2 * CMAX + 1)) + CMIN;
        y0 = int'($urandom_range(2 * CMAX + 1)) + CMIN;
        sz = $urandom_range(99);
        if (sz < 88) begin
            x1 = near_coord(x0, 12);
            y1 = near_coord(y0, 12);
        end else if (sz < 97) begin
            x1 = near_coord(x0, 100);
            y1 = near_coord(y0, 100);
        end else begin
            x1 = int'($urandom_range(2 * CMAX + 1)) + CMIN;
            y1 = int'($urandom_range(2 * CMAX + 1)) + CMIN;
        end
        m = $urandom_range(99);
        limit = (m >= 80 && m < 90) ? $urandom_range(0, 6) : (1 << 20);
        if (sz >= 97 && limit > 40)
            limit = $urandom_range(3, 40);
        send_start(x0, y0, x1, y1, $urandom);
        n = 0;
        while (sb.busy && n < limit) begin
            send_step();
            n++;
        end
        if (m >= 90)
            repeat ($urandom_range(1, 2)) send_step();
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step with no line: nothing comes out
        send_step();
        // single points: first pixel is also the last, block stays idle
        send_start(0, 0, 0, 0, 32'h0000_0000);
        send_step();
        send_start(CMIN, CMAX, CMIN, CMAX, 32'hFFFF_FFFF);
        // full-span diagonal, tie on the deltas so y is major
        send_start(CMIN, CMIN, CMAX, CMAX, 32'hA5A5_A5A5);
        repeat (3) send_step();
        // new start mid-line drops it; x major, negative, widest x delta
        send_start(CMAX, CMAX, CMIN, CMAX - 1, 32'h5A5A_5A5A);
        repeat (2) send_step();
        // x major stepping left with zero dy, then a step past the end
        send_start(5, 3, 2, 3, 32'h1234_5678);
        repeat (4) send_step();
        // y major stepping down with zero dx
        send_start(0, 0, 0, -2, 32'h8765_4321);
        repeat (2) send_step();
        // shallow slope where the minor axis moves partway
        send_start(1, 1, 4, 3, 32'hDEAD_BEEF);
        repeat (4) send_step();
        drain_pixels();

        while (n_items < ITEM_TARGET) begin
            quiet <= (n_items >= 300 && n_items < 500);
            if (!pressure_done && n_items >= 700) begin
                drain_pixels();
                pressure_done = 1'b1;
            end
            random_line();
        end

        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        // let any stray extra pixel show up
        repeat (8) @(posedge clk);
        if (sb.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
